[rtl/dtec_pkg.sv]
// shared constants, types and tables for the direction to texture coordinate unit
`timescale 1ns / 1ps
`default_nettype none
package dtec_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int ANGLE_BITS     = 16;
  localparam int TEX_FRAC_BITS  = 16;

  localparam int PRESCALE_SHIFT = 20;
  localparam int CORDIC_STEPS   = 30;
  localparam int CW             = COORD_WIDTH + PRESCALE_SHIFT + 4;
  localparam int AW             = 34;
  localparam int ANG_SHIFT      = 32 - ANGLE_BITS;

  localparam int GAIN_W         = 31;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195364;
  localparam int MULT_W         = COORD_WIDTH + GAIN_W;
  localparam int ZK_SHIFT       = 10;

  localparam int AZ_W           = ANGLE_BITS + 1;
  localparam int TEX_W          = TEX_FRAC_BITS + 1;
  localparam int NUM_W          = ANGLE_BITS + 1;
  localparam int ND_W           = NUM_W + 2;
  localparam int DIV_STEPS      = TEX_FRAC_BITS + 1;
  localparam int DIVD_W         = NUM_W + TEX_FRAC_BITS + 1;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic signed [AW-1:0] HALF_TURN    = AW'(1) <<< 31;
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(1) <<< 30;
  localparam logic signed [AW-1:0] ROUND_ADD    = AW'(1) <<< (ANG_SHIFT - 1);
  localparam logic signed [AW-1:0] HALF_BAM     = AW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [AW-1:0] QUARTER_BAM  = AW'(1) <<< (ANGLE_BITS - 2);

  localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1) << TEX_FRAC_BITS;

  localparam logic [AZ_W-1:0]              AZ_MIN_RST = '0;
  localparam logic [AZ_W-1:0]              AZ_MAX_RST = AZ_W'(1) << ANGLE_BITS;
  localparam logic signed [ANGLE_BITS-1:0] EL_MAX_RST = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);
  localparam logic signed [ANGLE_BITS-1:0] EL_MIN_RST = -EL_MAX_RST;

  // arctangent of 2^-i, 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef enum logic [1:0] {
    REG_AZ_MIN,
    REG_AZ_MAX,
    REG_EL_MIN,
    REG_EL_MAX
  } cfg_reg_t;

  // sideband that rides along both rotator pipelines
  typedef struct packed {
    logic                 zero;
    logic                 y_zero;
    logic                 x_neg;
    logic                 z_pos;
    logic                 mag_zero;
    logic signed [CW-1:0] zk;
    logic [AZ_W-1:0]      az;
  } side_t;

  typedef struct packed {
    logic res_zero;
    logic res_one;
    logic invert;
  } lane_mode_t;

  typedef struct packed {
    lane_mode_t       mode;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_lane_t;

endpackage
`default_nettype wire

[rtl/dtec_dir_if.sv]
// direction item channel
`timescale 1ns / 1ps
`default_nettype none
interface dtec_dir_if;
  import dtec_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface
`default_nettype wire

[rtl/dtec_tex_if.sv]
// texture coordinate item channel
`timescale 1ns / 1ps
`default_nettype none
interface dtec_tex_if;
  import dtec_pkg::*;
  logic             valid;
  logic             ready;
  logic [TEX_W-1:0] tex_u;
  logic [TEX_W-1:0] tex_v;
  logic             degenerate;
  modport source (output valid, tex_u, tex_v, degenerate, input ready);
  modport sink   (input valid, tex_u, tex_v, degenerate, output ready);
endinterface
`default_nettype wire

[rtl/dtec_cordic.sv]
// pipelined vectoring rotator: a half-plane fold stage, then one micro-rotation per stage
`timescale 1ns / 1ps
`default_nettype none
module dtec_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [dtec_pkg::CW-1:0] in_x,
  input  logic signed [dtec_pkg::CW-1:0] in_y,
  input  dtec_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic signed [dtec_pkg::AW-1:0] out_ang,
  output logic signed [dtec_pkg::CW-1:0] out_mag,
  output dtec_pkg::side_t               out_side
);
  import dtec_pkg::*;

  logic                 vld [0:CORDIC_STEPS];
  logic signed [CW-1:0] xs  [0:CORDIC_STEPS];
  logic signed [CW-1:0] ys  [0:CORDIC_STEPS];
  logic signed [AW-1:0] ang [0:CORDIC_STEPS];
  side_t                sd  [0:CORDIC_STEPS];

  // left half plane folded over by a half turn
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= in_side;
      if (in_x < 0) begin
        xs[0]  <= -in_x;
        ys[0]  <= -in_y;
        ang[0] <= (in_y >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        xs[0]  <= in_x;
        ys[0]  <= in_y;
        ang[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [AW-1:0] ATAN_I = AW'(ATAN_TAB[i]);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[i+1] <= sd[i];
        if (ys[i] > 0) begin
          xs[i+1]  <= xs[i] + dx;
          ys[i+1]  <= ys[i] - dy;
          ang[i+1] <= ang[i] + ATAN_I;
        end else begin
          xs[i+1]  <= xs[i] - dx;
          ys[i+1]  <= ys[i] + dy;
          ang[i+1] <= ang[i] - ATAN_I;
        end
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_ang   = ang[CORDIC_STEPS];
  assign out_mag   = xs[CORDIC_STEPS];
  assign out_side  = sd[CORDIC_STEPS];

endmodule
`default_nettype wire

[rtl/dtec_div.sv]
// two-lane pipelined restoring divider, one quotient bit per stage, with output mapping
`timescale 1ns / 1ps
`default_nettype none
module dtec_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic                                 in_deg,
  input  dtec_pkg::div_lane_t [1:0]            in_lane,
  output logic                                 out_valid,
  output logic                                 out_deg,
  output logic [1:0][dtec_pkg::TEX_W-1:0]      out_val
);
  import dtec_pkg::*;

  typedef struct packed {
    lane_mode_t           mode;
    logic [NUM_W-1:0]     den;
    logic [NUM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] bits;
    logic [DIV_STEPS-1:0] quo;
  } div_st_t;

  div_st_t [1:0] st0;
  logic          vld [1:DIV_STEPS];
  logic          deg [1:DIV_STEPS];
  div_st_t [1:0] st  [1:DIV_STEPS];

  // dividend is num * one plus half the divisor, so the quotient rounds half up
  always_comb begin
    logic [DIVD_W-1:0] dvd;
    for (int l = 0; l < 2; l++) begin
      dvd = DIVD_W'({in_lane[l].num, TEX_FRAC_BITS'(0)}) + DIVD_W'(in_lane[l].den >> 1);
      st0[l].mode = in_lane[l].mode;
      st0[l].den  = in_lane[l].den;
      st0[l].rem  = dvd[DIVD_W-1:DIV_STEPS];
      st0[l].bits = dvd[DIV_STEPS-1:0];
      st0[l].quo  = '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_bit
    logic          cv;
    logic          cd;
    div_st_t [1:0] cs;
    div_st_t [1:0] ns;

    if (k == 0) begin : g_head
      assign cv = in_valid;
      assign cd = in_deg;
      assign cs = st0;
    end else begin : g_body
      assign cv = vld[k];
      assign cd = deg[k];
      assign cs = st[k];
    end

    always_comb begin
      logic [NUM_W:0] trial;
      ns = cs;
      for (int l = 0; l < 2; l++) begin
        trial = {cs[l].rem, cs[l].bits[DIV_STEPS-1-k]};
        if (trial >= {1'b0, cs[l].den}) begin
          trial      = trial - {1'b0, cs[l].den};
          ns[l].quo  = {cs[l].quo[DIV_STEPS-2:0], 1'b1};
        end else begin
          ns[l].quo  = {cs[l].quo[DIV_STEPS-2:0], 1'b0};
        end
        ns[l].rem = trial[NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        deg[k+1] <= cd;
        st[k+1]  <= ns;
      end
    end
  end

  // saturate, force and invert into the output register
  logic [1:0][TEX_W-1:0] val_next;

  always_comb begin
    logic [TEX_W-1:0] t;
    for (int l = 0; l < 2; l++) begin
      if (st[DIV_STEPS][l].mode.res_zero) begin
        t = '0;
      end else if (st[DIV_STEPS][l].mode.res_one || st[DIV_STEPS][l].quo > TEX_ONE) begin
        t = TEX_ONE;
      end else begin
        t = st[DIV_STEPS][l].quo;
      end
      val_next[l] = st[DIV_STEPS][l].mode.invert ? TEX_ONE - t : t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_deg <= deg[DIV_STEPS];
      out_val <= val_next;
    end
  end

endmodule
`default_nettype wire

[rtl/direction_to_equirect_texcoord_unit.sv]
// top level: direction vector to equirectangular texture coordinate
//
//   channel   kind          dir   carries
//   dir_in    valid/ready   in    dir_x, dir_y, dir_z (signed 24 bit)
//   tex_out   valid/ready   out   tex_u, tex_v (Q1.16), degenerate
//   apb       psel/penable  in    azimuth / elevation range registers
//
// one item per clock sustained while the output is not stalled
// the pipe is made of two 31-stage rotators, the 17-stage divider and four single stages
// the whole pipe moves on one advance enable: free output register or sink ready
// a stall freezes every stage in place, bubbles stay bubbles
// synchronous reset clears valid bits and loads the default ranges
`timescale 1ns / 1ps
`default_nettype none
module direction_to_equirect_texcoord_unit (
  input  logic                          clk,
  input  logic                          rst,
  dtec_dir_if.sink                      dir_in,
  dtec_tex_if.source                    tex_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtec_pkg::ADDR_W-1:0]   paddr,
  input  logic [dtec_pkg::DATA_W-1:0]   pwdata,
  output logic [dtec_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import dtec_pkg::*;

  // range registers
  logic [AZ_W-1:0]              az_min;
  logic [AZ_W-1:0]              az_max;
  logic signed [ANGLE_BITS-1:0] el_min;
  logic signed [ANGLE_BITS-1:0] el_max;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      az_min <= AZ_MIN_RST;
      az_max <= AZ_MAX_RST;
      el_min <= EL_MIN_RST;
      el_max <= EL_MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[3:2]))
        REG_AZ_MIN: az_min <= pwdata[AZ_W-1:0];
        REG_AZ_MAX: az_max <= pwdata[AZ_W-1:0];
        REG_EL_MIN: el_min <= pwdata[ANGLE_BITS-1:0];
        REG_EL_MAX: el_max <= pwdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_AZ_MIN: prdata = DATA_W'(az_min);
      REG_AZ_MAX: prdata = DATA_W'(az_max);
      REG_EL_MIN: prdata = DATA_W'(el_min);
      REG_EL_MAX: prdata = DATA_W'(el_max);
      default:    prdata = '0;
    endcase
  end

  // global advance: the output register is free or being drained
  logic adv;
  assign adv          = !tex_out.valid || tex_out.ready;
  assign dir_in.ready = adv;

  // prep stage: prescale x and y, gain-correct z for the elevation rotator
  logic                 p_vld;
  logic signed [CW-1:0] p_x;
  logic signed [CW-1:0] p_y;
  side_t                p_side;
  logic signed [MULT_W-1:0] z_prod;

  assign z_prod = MULT_W'(dir_in.dir_z) * $signed(MULT_W'(GAIN_Q30));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= dir_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x             <= CW'(dir_in.dir_x) <<< PRESCALE_SHIFT;
      p_y             <= CW'(dir_in.dir_y) <<< PRESCALE_SHIFT;
      p_side.zero     <= (dir_in.dir_x == '0) && (dir_in.dir_y == '0) && (dir_in.dir_z == '0);
      p_side.y_zero   <= (dir_in.dir_y == '0);
      p_side.x_neg    <= dir_in.dir_x[COORD_WIDTH-1];
      p_side.z_pos    <= (dir_in.dir_z > 0);
      p_side.mag_zero <= 1'b0;
      p_side.zk       <= CW'(z_prod >>> ZK_SHIFT);
      p_side.az       <= '0;
    end
  end

  // azimuth rotator
  logic                 a_vld;
  logic signed [AW-1:0] a_ang;
  logic signed [CW-1:0] a_mag;
  side_t                a_side;

  dtec_cordic u_az_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (p_vld),
    .in_x     (p_x),
    .in_y     (p_y),
    .in_side  (p_side),
    .out_valid(a_vld),
    .out_ang  (a_ang),
    .out_mag  (a_mag),
    .out_side (a_side)
  );

  // middle stage: azimuth to angle units, offset by a half turn
  logic                 m_vld;
  logic signed [CW-1:0] m_x;
  logic signed [CW-1:0] m_y;
  side_t                m_side;
  side_t                m_side_next;
  logic [AZ_W-1:0]      az_next;

  always_comb begin
    logic signed [AW-1:0] a32;
    logic signed [AW-1:0] ar;
    // exact horizontal axis overrides the rotator residue
    if (a_side.y_zero) begin
      a32 = a_side.x_neg ? HALF_TURN : '0;
    end else begin
      a32 = a_ang;
    end
    ar = (a32 + ROUND_ADD) >>> ANG_SHIFT;
    if (ar > HALF_BAM) begin
      ar = HALF_BAM;
    end else if (ar < -HALF_BAM) begin
      ar = -HALF_BAM;
    end
    ar      = ar + HALF_BAM;
    az_next = ar[AZ_W-1:0];
    m_side_next          = a_side;
    m_side_next.az       = az_next;
    m_side_next.mag_zero = (a_mag == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_x    <= a_mag;
      m_y    <= a_side.zk;
      m_side <= m_side_next;
    end
  end

  // elevation rotator: horizontal leg against scaled z
  logic                 e_vld;
  logic signed [AW-1:0] e_ang;
  logic signed [CW-1:0] e_mag;
  side_t                e_side;

  dtec_cordic u_el_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (m_vld),
    .in_x     (m_x),
    .in_y     (m_y),
    .in_side  (m_side),
    .out_valid(e_vld),
    .out_ang  (e_ang),
    .out_mag  (e_mag),
    .out_side (e_side)
  );

  // final setup stage: elevation to angle units, range offsets, special cases
  logic                 f_vld;
  logic                 f_deg;
  div_lane_t [1:0]      f_lane;
  logic                 deg_next;
  div_lane_t [1:0]      lane_next;
  logic                 e_mag_unused;

  // rotator gain on the elevation leg is of no interest
  assign e_mag_unused = ^e_mag;

  always_comb begin
    logic signed [AW-1:0]   e32;
    logic signed [AW-1:0]   er;
    logic signed [ND_W-1:0] num_a;
    logic signed [ND_W-1:0] den_a;
    logic signed [ND_W-1:0] num_e;
    logic signed [ND_W-1:0] den_e;
    // straight up or down: no horizontal leg
    if (e_side.mag_zero) begin
      e32 = e_side.z_pos ? QUARTER_TURN : -QUARTER_TURN;
    end else begin
      e32 = e_ang;
    end
    er = (e32 + ROUND_ADD) >>> ANG_SHIFT;
    if (er > QUARTER_BAM) begin
      er = QUARTER_BAM;
    end else if (er < -QUARTER_BAM) begin
      er = -QUARTER_BAM;
    end

    num_a = $signed({2'b00, e_side.az}) - $signed({2'b00, az_min});
    den_a = $signed({2'b00, az_max}) - $signed({2'b00, az_min});
    num_e = ND_W'(er) - ND_W'(el_min);
    den_e = ND_W'(el_max) - ND_W'(el_min);

    // zero vector or an empty range
    deg_next = e_side.zero || (den_a <= 0) || (den_e <= 0);

    lane_next[0].mode.res_zero = deg_next || (num_a <= 0);
    lane_next[0].mode.res_one  = (num_a >= den_a);
    lane_next[0].mode.invert   = 1'b0;
    lane_next[0].num           = num_a[NUM_W-1:0];
    lane_next[0].den           = den_a[NUM_W-1:0];

    // vertical is inverted unless the item is degenerate
    lane_next[1].mode.res_zero = deg_next || (num_e <= 0);
    lane_next[1].mode.res_one  = (num_e >= den_e);
    lane_next[1].mode.invert   = !deg_next;
    lane_next[1].num           = num_e[NUM_W-1:0];
    lane_next[1].den           = den_e[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_deg  <= deg_next ^ (e_mag_unused & 1'b0);
      f_lane <= lane_next;
    end
  end

  // normalizing divider, output register lives inside
  logic                  d_deg;
  logic [1:0][TEX_W-1:0] d_val;

  dtec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (f_vld),
    .in_deg   (f_deg),
    .in_lane  (f_lane),
    .out_valid(tex_out.valid),
    .out_deg  (d_deg),
    .out_val  (d_val)
  );

  assign tex_out.tex_u      = d_val[0];
  assign tex_out.tex_v      = d_val[1];
  assign tex_out.degenerate = d_deg;

endmodule
`default_nettype wire

[rtl/dtec_checker.sv]
// port-level checks for the direction to texture coordinate unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dtec_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dtec_pkg::TEX_W-1:0] tex_u,
  input logic [dtec_pkg::TEX_W-1:0] tex_v,
  input logic                       degenerate
);
  import dtec_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tex_u) && $stable(tex_v)
      && $stable(degenerate))
    else $error("output item changed while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> tex_u == '0 && tex_v == '0)
    else $error("degenerate item with nonzero coordinates");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_u <= TEX_ONE && tex_v <= TEX_ONE)
    else $error("coordinate above one");

  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output drain");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind direction_to_equirect_texcoord_unit dtec_checker u_dtec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (dir_in.ready),
  .out_valid (tex_out.valid),
  .out_ready (tex_out.ready),
  .tex_u     (tex_out.tex_u),
  .tex_v     (tex_out.tex_v),
  .degenerate(tex_out.degenerate)
);
`default_nettype wire
